>>> rtl/fcspm_pkg.sv
package fcspm_pkg;

  typedef enum logic [3:0] {
    CMD_TICK   = 4'd0,
    CMD_ADDR   = 4'd1,
    CMD_LEN    = 4'd2,
    CMD_PERIOD = 4'd3,
    CMD_VOL    = 4'd4,
    CMD_LOOP   = 4'd5,
    CMD_NEXT   = 4'd6,
    CMD_DMACON = 4'd7,
    CMD_DMAOFF = 4'd8,
    CMD_POLL   = 4'd9,
    CMD_STATUS = 4'd10,
    CMD_RESET  = 4'd11,
    CMD_MEMWR  = 4'd12
  } cmd_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EVAL  = 7'b0000010,
    S_ADDR  = 7'b0000100,
    S_MEM   = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  localparam logic [22:0] CLOCK_RESET = 23'd3546895;
  localparam logic [17:0] RATE_RESET  = 18'd48000;
  localparam logic [6:0]  GAIN_MAX    = 7'd64;
  localparam logic [4:0]  DIV_TOP     = 5'd26;
  localparam logic [2:0]  ADDR_RATE   = 3'd4;

endpackage

>>> rtl/four_channel_sample_player_mixer_core.sv
// Register commands go through S_FIN, which raises the out_valid strobe; a period command
// first runs the step division (S_MUL, S_DIV; one 60-bit compare/subtract per quotient bit).
// A tick walks the four channels in turn through one evaluator, one sample memory port and one
// multiplier (S_EVAL, S_ADDR, S_MEM; S_EVAL alone if silent); a queued new-period swap divides.
// busy stays high until the strobe; the receiver cannot stall. SAMPLE_MEM_DEPTH is a power of two.
// Synchronous reset clears all channel state and restores the default clock and rate registers.
module four_channel_sample_player_mixer_core #(
  parameter int SAMPLE_MEM_DEPTH = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         cmd,
  input  logic [1:0]         channel,
  input  logic [15:0]        address,
  input  logic [15:0]        length_words,
  input  logic [15:0]        period,
  input  logic [7:0]         volume,
  input  logic               loop_mode,
  input  logic [15:0]        dma_control,
  input  logic signed [7:0]  mem_data,
  output logic               out_valid,
  output logic signed [13:0] left,
  output logic signed [13:0] right,
  output logic [3:0]         active_mask,
  output logic               completed,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = $clog2(SAMPLE_MEM_DEPTH);

  fcspm_pkg::state_t state;

  logic [22:0] clock_hz;
  logic [17:0] rate_hz;

  logic [15:0] base_addr [4];
  logic        present   [4];
  logic [16:0] len_b     [4];
  logic [33:0] pos       [4];
  logic [25:0] step      [4];
  logic [6:0]  gain      [4];
  logic [3:0]  dma_en;
  logic        rpt       [4];
  logic [15:0] q_addr    [4];
  logic        q_present [4];
  logic [16:0] q_len     [4];
  logic        q_rpt     [4];
  logic [15:0] q_per     [4];
  logic [6:0]  q_gain    [4];
  logic        q_gv      [4];
  logic        q_valid   [4];
  logic [3:0]  done_f;

  logic [7:0]  mem [SAMPLE_MEM_DEPTH];
  logic [7:0]  mem_q;

  logic        tick_q;
  logic        comp_q;
  logic [1:0]  slot;
  logic [16:0] acc_l;
  logic [16:0] acc_r;

  logic [15:0] div_per;
  logic [1:0]  div_ch;
  logic        div_tick;
  logic [33:0] den;
  logic [38:0] rem;
  logic [4:0]  div_k;
  logic [25:0] quo;

  logic [1:0]  ch;
  logic [6:0]  vol_sat;
  logic        accept;
  logic        cfg_wr;
  logic [17:0] idx;
  logic        past_end;
  logic [33:0] pos_loop;
  logic        silent;
  logic [33:0] fsum;
  logic [33:0] wsum;
  logic [59:0] den_sh;
  logic        div_ge;
  logic signed [15:0] prod;

  always_comb begin
    unique case (slot)
      2'd0:    ch = 2'd0;
      2'd1:    ch = 2'd3;
      2'd2:    ch = 2'd1;
      default: ch = 2'd2;
    endcase
  end

  assign accept   = start && !busy;
  assign busy     = state != fcspm_pkg::S_IDLE;
  assign vol_sat  = (volume > {1'b0, fcspm_pkg::GAIN_MAX}) ? fcspm_pkg::GAIN_MAX : volume[6:0];
  assign idx      = pos[ch][33:16];
  assign past_end = idx >= {1'b0, len_b[ch]};
  assign pos_loop = pos[ch] - {1'b0, len_b[ch], 16'b0};
  assign silent   = !dma_en[ch] || step[ch] == '0 || !present[ch] || len_b[ch] == '0;
  assign fsum     = {18'b0, base_addr[ch]} + {16'b0, idx};
  assign wsum     = {18'b0, address};
  assign den_sh   = {26'b0, den} << div_k;
  assign div_ge   = {21'b0, rem} >= den_sh;
  assign prod     = $signed(mem_q) * $signed({1'b0, gain[ch]});
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign prdata   = (paddr == fcspm_pkg::ADDR_RATE) ? {14'b0, rate_hz} :
                    (paddr == '0) ? {9'b0, clock_hz} : '0;

  always_ff @(posedge clk) begin
    if (cfg_wr) begin
      if (paddr[2]) begin
        rate_hz <= pwdata[17:0];
      end else begin
        clock_hz <= pwdata[22:0];
      end
    end
    if (rst) begin
      clock_hz <= fcspm_pkg::CLOCK_RESET;
      rate_hz  <= fcspm_pkg::RATE_RESET;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd == fcspm_pkg::CMD_MEMWR) begin
      mem[wsum[AW-1:0]] <= mem_data;
    end
    if (state == fcspm_pkg::S_ADDR) begin
      mem_q <= mem[fsum[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    out_valid <= 1'b0;
    if (rst || (accept && cmd == fcspm_pkg::CMD_RESET)) begin
      for (int i = 0; i < 4; i++) begin
        base_addr[i] <= '0;
        present[i]   <= 1'b0;
        len_b[i]     <= '0;
        pos[i]       <= '0;
        step[i]      <= '0;
        gain[i]      <= '0;
        rpt[i]       <= 1'b0;
        q_addr[i]    <= '0;
        q_present[i] <= 1'b0;
        q_len[i]     <= '0;
        q_rpt[i]     <= 1'b0;
        q_per[i]     <= '0;
        q_gain[i]    <= '0;
        q_gv[i]      <= 1'b0;
        q_valid[i]   <= 1'b0;
      end
      dma_en <= '0;
      done_f <= '0;
      tick_q <= 1'b0;
      comp_q <= 1'b0;
      state  <= rst ? fcspm_pkg::S_IDLE : fcspm_pkg::S_FIN;
    end else begin
      unique case (state)
        fcspm_pkg::S_IDLE: begin
          if (accept) begin
            tick_q <= cmd == fcspm_pkg::CMD_TICK;
            comp_q <= 1'b0;
            acc_l  <= '0;
            acc_r  <= '0;
            slot   <= '0;
            state  <= fcspm_pkg::S_FIN;
            case (cmd)
              fcspm_pkg::CMD_TICK: state <= fcspm_pkg::S_EVAL;
              fcspm_pkg::CMD_ADDR: begin
                base_addr[channel] <= address;
                present[channel]   <= 1'b1;
                pos[channel]       <= '0;
              end
              fcspm_pkg::CMD_LEN: len_b[channel] <= {length_words, 1'b0};
              fcspm_pkg::CMD_PERIOD: begin
                if (period != '0) begin
                  div_per  <= period;
                  div_ch   <= channel;
                  div_tick <= 1'b0;
                  state    <= fcspm_pkg::S_MUL;
                end
              end
              fcspm_pkg::CMD_VOL:  gain[channel] <= vol_sat;
              fcspm_pkg::CMD_LOOP: rpt[channel] <= loop_mode;
              fcspm_pkg::CMD_NEXT: begin
                q_addr[channel]    <= address;
                q_present[channel] <= 1'b1;
                q_len[channel]     <= {length_words, 1'b0};
                q_rpt[channel]     <= loop_mode;
                q_per[channel]     <= period;
                q_gain[channel]    <= vol_sat;
                q_gv[channel]      <= 1'b1;
                q_valid[channel]   <= 1'b1;
              end
              fcspm_pkg::CMD_DMACON: begin
                for (int i = 0; i < 4; i++) begin
                  if (dma_control[i]) begin
                    dma_en[i] <= dma_control[15];
                    if (dma_control[15]) begin
                      pos[i]    <= '0;
                      done_f[i] <= 1'b0;
                    end
                  end
                end
              end
              fcspm_pkg::CMD_DMAOFF: begin
                dma_en[channel]  <= 1'b0;
                q_valid[channel] <= 1'b0;
                done_f[channel]  <= 1'b0;
              end
              fcspm_pkg::CMD_POLL: begin
                comp_q          <= done_f[channel];
                done_f[channel] <= 1'b0;
              end
              fcspm_pkg::CMD_STATUS: comp_q <= done_f[channel];
              default: ;
            endcase
          end
        end
        fcspm_pkg::S_EVAL: begin
          if (silent) begin
            slot  <= slot + 2'd1;
            state <= (slot == 2'd3) ? fcspm_pkg::S_FIN : fcspm_pkg::S_EVAL;
          end else if (!past_end) begin
            state <= fcspm_pkg::S_ADDR;
          end else if (rpt[ch]) begin
            pos[ch] <= (pos_loop[33:16] >= {1'b0, len_b[ch]}) ? '0 : pos_loop;
            state   <= fcspm_pkg::S_ADDR;
          end else if (q_valid[ch]) begin
            base_addr[ch] <= q_addr[ch];
            present[ch]   <= q_present[ch];
            len_b[ch]     <= q_len[ch];
            rpt[ch]       <= q_rpt[ch];
            if (q_gv[ch]) begin
              gain[ch] <= q_gain[ch];
            end
            q_valid[ch] <= 1'b0;
            q_gv[ch]    <= 1'b0;
            pos[ch]     <= '0;
            done_f[ch]  <= 1'b1;
            if (q_per[ch] != '0) begin
              div_per  <= q_per[ch];
              div_ch   <= ch;
              div_tick <= 1'b1;
              state    <= fcspm_pkg::S_MUL;
            end else begin
              state <= fcspm_pkg::S_ADDR;
            end
          end else begin
            dma_en[ch] <= 1'b0;
            done_f[ch] <= 1'b1;
            slot       <= slot + 2'd1;
            state      <= (slot == 2'd3) ? fcspm_pkg::S_FIN : fcspm_pkg::S_EVAL;
          end
        end
        fcspm_pkg::S_ADDR: begin
          pos[ch] <= pos[ch] + {8'b0, step[ch]};
          state   <= fcspm_pkg::S_MEM;
        end
        fcspm_pkg::S_MEM: begin
          if (slot[1]) begin
            acc_r <= acc_r + {prod[15], prod};
          end else begin
            acc_l <= acc_l + {prod[15], prod};
          end
          slot  <= slot + 2'd1;
          state <= (slot == 2'd3) ? fcspm_pkg::S_FIN : fcspm_pkg::S_EVAL;
        end
        fcspm_pkg::S_MUL: begin
          den   <= {18'b0, div_per} * {16'b0, rate_hz};
          rem   <= {clock_hz, 16'b0};
          div_k <= fcspm_pkg::DIV_TOP;
          quo   <= '0;
          state <= fcspm_pkg::S_DIV;
        end
        fcspm_pkg::S_DIV: begin
          if (div_ge && div_k == fcspm_pkg::DIV_TOP) begin
            step[div_ch] <= '1;
            state        <= div_tick ? fcspm_pkg::S_ADDR : fcspm_pkg::S_FIN;
          end else begin
            if (div_ge) begin
              rem             <= rem - den_sh[38:0];
              quo[div_k]      <= 1'b1;
            end
            if (div_k == '0) begin
              step[div_ch] <= {quo[25:1], div_ge};
              state        <= div_tick ? fcspm_pkg::S_ADDR : fcspm_pkg::S_FIN;
            end else begin
              div_k <= div_k - 5'd1;
            end
          end
        end
        fcspm_pkg::S_FIN: begin
          out_valid   <= 1'b1;
          left        <= tick_q ? acc_l[14:1] : '0;
          right       <= tick_q ? acc_r[14:1] : '0;
          active_mask <= dma_en;
          completed   <= comp_q;
          state       <= fcspm_pkg::S_IDLE;
        end
        default: state <= fcspm_pkg::S_IDLE;
      endcase
    end
  end

  a_strobe_after_fin: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(state == fcspm_pkg::S_FIN)) else $error("strobe without finish");
  a_mix_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tick_q |-> left == '0 && right == '0) else $error("mix on non-tick");
  a_div_range: assert property (@(posedge clk) disable iff (rst)
    state == fcspm_pkg::S_DIV |-> div_k <= fcspm_pkg::DIV_TOP) else $error("divider index");
  a_busy_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("not busy after transfer");

endmodule
